FILE: hw/rtl/mahs_pkg.sv
// mahs_pkg: widths, reset values, register indexes and FSM type of the
// moving-average hysteresis switch. No dependencies.
package mahs_pkg;

    localparam int WINDOW   = 10;
    localparam int SMP_W    = 12;
    localparam int SUM_W    = 18;
    localparam int FILL_W   = $clog2(WINDOW + 1);
    localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int DCNT_W   = $clog2(SUM_W + 1);
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [SMP_W-1:0] DARK_RST  = SMP_W'(1800);
    localparam logic [SMP_W-1:0] LIGHT_RST = SMP_W'(2200);

    localparam logic REG_DARK  = 1'b0;
    localparam logic REG_LIGHT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_DIV
    } t_state;

    typedef struct packed {
        logic [SMP_W-1:0] dark;
        logic [SMP_W-1:0] light;
    } t_thresh;

endpackage

FILE: hw/rtl/mahs_ifs.sv
// mahs_in_if / mahs_out_if: valid/ready channels for samples and results.
// Depends on mahs_pkg.
interface mahs_in_if;
    import mahs_pkg::*;
    logic             valid;
    logic             ready;
    logic [SMP_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mahs_out_if;
    import mahs_pkg::*;
    logic             valid;
    logic             ready;
    logic [SMP_W-1:0] average;
    logic             lamp_on;
    logic             switched;
    modport source (output valid, output average, output lamp_on, output switched,
                    input ready);
    modport sink   (input valid, input average, input lamp_on, input switched,
                    output ready);
endinterface

FILE: hw/rtl/mahs_cfg.sv
// mahs_cfg: APB register file holding the dark and light thresholds.
// Depends on mahs_pkg.
module mahs_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mahs_pkg::PADDR_W-1:0]  paddr,
    input  logic [mahs_pkg::PDATA_W-1:0]  pwdata,
    output logic [mahs_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output mahs_pkg::t_thresh             o_thresh
);
    import mahs_pkg::*;

    logic [SMP_W-1:0] r_dark;
    logic [SMP_W-1:0] r_light;
    logic             wr_en;

    // byte address 4*i, low two bits ignored
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark  <= DARK_RST;
            r_light <= LIGHT_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_DARK:  r_dark  <= pwdata[SMP_W-1:0];
                REG_LIGHT: r_light <= pwdata[SMP_W-1:0];
                default:   r_dark  <= r_dark;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DARK:  prdata = PDATA_W'(r_dark);
            REG_LIGHT: prdata = PDATA_W'(r_light);
            default:   prdata = '0;
        endcase
    end

    assign o_thresh.dark  = r_dark;
    assign o_thresh.light = r_light;

endmodule

FILE: hw/rtl/mahs_ring.sv
// mahs_ring: sample ring memory, one write port, one registered read port.
// Depends on mahs_pkg.
module mahs_ring (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [mahs_pkg::PTR_W-1:0]  i_rd_addr,
    output logic [mahs_pkg::SMP_W-1:0]  o_rd_data,
    input  logic                        i_wr_en,
    input  logic [mahs_pkg::PTR_W-1:0]  i_wr_addr,
    input  logic [mahs_pkg::SMP_W-1:0]  i_wr_data
);
    import mahs_pkg::*;

    logic [SMP_W-1:0] mem [WINDOW];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

FILE: hw/rtl/mahs_div.sv
// mahs_div: restoring divider, one quotient bit per cycle.
// Depends on mahs_pkg.
module mahs_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mahs_pkg::SUM_W-1:0]   i_dividend,
    input  logic [mahs_pkg::FILL_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [mahs_pkg::SMP_W-1:0]   o_quot
);
    import mahs_pkg::*;

    logic [SUM_W-1:0]  r_dvd;
    logic [FILL_W-1:0] r_rem;
    logic [FILL_W-1:0] r_dsr;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [FILL_W:0]   trial;
    logic [FILL_W:0]   diff;
    logic              ge;

    assign trial = {r_rem, r_dvd[SUM_W-1]};
    assign ge    = trial >= {1'b0, r_dsr};
    assign diff  = trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DCNT_W'(SUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[SUM_W-2:0], ge};
            r_rem <= ge ? diff[FILL_W-1:0] : trial[FILL_W-1:0];
        end
    end

    // mean of 12-bit samples always fits 12 bits
    assign o_done = r_done;
    assign o_quot = r_dvd[SMP_W-1:0];

endmodule

FILE: hw/rtl/moving_average_hysteresis_switch_core.sv
// moving_average_hysteresis_switch_core: top level; ring memory, running sum,
// divider and hysteresis switch. Depends on mahs_pkg, mahs_ifs, mahs_cfg,
// mahs_ring, mahs_div.
//
//  channel   dir   handshake        payload
//  in_ch     in    valid / ready    sample[11:0]
//  out_ch    out   valid / ready    average[11:0], lamp_on, switched
//  apb       in    psel/penable     dark (0x0), light (0x4) thresholds
//
// Sequence: an item is accepted in S_IDLE and the oldest ring entry is read;
// in S_SUM the sum is updated and the divider started; in S_DIV the divider
// finds one quotient bit per cycle, then the result is loaded. The block takes
// one item at a time; the next sample can be taken the cycle after the load.
// Reset: synchronous, active low; clears sum, fill count, write pointer and
// lamp state. The ring is not cleared: a read entry is only used once full.
// Stalls: a result waits in the output register; the block still accepts the
// next request and only holds in the divide state if the previous result has
// not been taken by the time the new one is ready.
module moving_average_hysteresis_switch_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mahs_in_if.sink                       in_ch,
    mahs_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mahs_pkg::PADDR_W-1:0]  paddr,
    input  logic [mahs_pkg::PDATA_W-1:0]  pwdata,
    output logic [mahs_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import mahs_pkg::*;

    t_state            r_state;
    t_state            n_state;
    t_thresh           thresh;

    // item state
    logic [PTR_W-1:0]  r_pos;
    logic [FILL_W-1:0] r_fill;
    logic [SUM_W-1:0]  r_sum;
    logic              r_lamp;
    logic [SMP_W-1:0]  r_sample;

    // output register
    logic              r_out_valid;
    logic [SMP_W-1:0]  r_out_avg;
    logic              r_out_lamp;
    logic              r_out_sw;

    // control strobes
    logic              accept;
    logic              ring_wr;
    logic              div_start;
    logic              out_load;

    logic [SMP_W-1:0]  rd_data;
    logic              full;
    logic [SUM_W-1:0]  n_sum;
    logic [FILL_W-1:0] n_fill;
    logic [PTR_W-1:0]  n_pos;
    logic              div_done;
    logic [SMP_W-1:0]  div_quot;
    logic              n_lamp;

    mahs_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_thresh (thresh)
    );

    // read the oldest entry at accept; the data is held from S_READ through S_SUM
    mahs_ring u_ring (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_pos),
        .o_rd_data (rd_data),
        .i_wr_en   (ring_wr),
        .i_wr_addr (r_pos),
        .i_wr_data (r_sample)
    );

    mahs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_fill),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // sum update: drop oldest only once the window is full
    assign full   = (r_fill == FILL_W'(WINDOW));
    assign n_sum  = full ? (r_sum - SUM_W'(rd_data) + SUM_W'(r_sample))
                         : (r_sum + SUM_W'(r_sample));
    assign n_fill = full ? r_fill : r_fill + 1'b1;
    assign n_pos  = (r_pos == PTR_W'(WINDOW - 1)) ? '0 : r_pos + 1'b1;

    // hysteresis on the fresh mean
    assign n_lamp = r_lamp ? !(div_quot > thresh.light) : (div_quot < thresh.dark);

    assign accept = in_ch.valid && in_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        in_ch.ready = 1'b0;
        ring_wr     = 1'b0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                in_ch.ready = 1'b1;
                if (in_ch.valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                ring_wr   = 1'b1;
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                // hold here while the divider runs or the previous result is still unclaimed
                if (div_done && (!r_out_valid || out_ch.ready)) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_fill <= '0;
            r_sum  <= '0;
            r_lamp <= 1'b0;
        end else begin
            if (ring_wr) begin
                r_pos  <= n_pos;
                r_fill <= n_fill;
                r_sum  <= n_sum;
            end
            if (out_load) begin
                r_lamp <= n_lamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= in_ch.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_avg  <= div_quot;
            r_out_lamp <= n_lamp;
            r_out_sw   <= n_lamp ^ r_lamp;
        end
    end

    assign out_ch.valid    = r_out_valid;
    assign out_ch.average  = r_out_avg;
    assign out_ch.lamp_on  = r_out_lamp;
    assign out_ch.switched = r_out_sw;

    // fill count never passes the window size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW))
        else $error("fill count above window");

    // write pointer stays inside the ring
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PTR_W'(WINDOW - 1))
        else $error("write pointer out of ring");

    // one item at a time: no request taken right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !in_ch.ready)
        else $error("request accepted while item in flight");

    // a loaded result carries the lamp state now held internally
    a_lamp_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_lamp == r_lamp) && r_out_valid)
        else $error("result lamp state mismatch");

endmodule
